// File: hw/rtl/srs_pkg.sv
// ---------------------------------------------------------------------------
// srs_pkg
// Shared types, codes and constants of the stochastic reaction step engine.
// ---------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

    // Defaults for top-level parameters
    localparam int MAX_REACTIONS_DEF = 64;
    localparam int MAX_SPECIES_DEF   = 32;

    // Fixed by the field widths
    localparam int MAX_PRODUCTS = 3;
    localparam int COUNT_BITS   = 24;
    localparam int TIME_W       = 48;
    localparam int RATE_W       = 32;
    localparam int PROP_W       = 64;
    localparam int DIVIDEND_W   = 48;
    localparam int IN_W         = 152;
    localparam int OUT_W        = 80;

    // Op codes
    localparam logic [2:0] OP_WR_RXN   = 3'd0;
    localparam logic [2:0] OP_WR_COUNT = 3'd1;
    localparam logic [2:0] OP_WR_SRC   = 3'd2;
    localparam logic [2:0] OP_RD_COUNT = 3'd3;
    localparam logic [2:0] OP_STEP     = 3'd4;
    localparam logic [2:0] OP_RESTART  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_PAST = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_TIME = 3'd0;
    localparam logic [2:0] CFG_END_TIME   = 3'd1;
    localparam logic [2:0] CFG_IRR_END    = 3'd2;
    localparam logic [2:0] CFG_RXN_COUNT  = 3'd3;
    localparam logic [2:0] CFG_NONE_SP    = 3'd4;

    typedef struct packed {
        logic [4:0]        p3;
        logic [4:0]        p2;
        logic [4:0]        p1;
        logic [RATE_W-1:0] k;
        logic              first;
        logic [4:0]        b;
        logic [4:0]        a;
    } t_rxn;

    function automatic logic [PROP_W-1:0] sat_add64(input logic [PROP_W-1:0] x,
                                                    input logic [PROP_W-1:0] y);
        logic [PROP_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[PROP_W] ? '1 : s[PROP_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srs_ram.sv
// ---------------------------------------------------------------------------
// srs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  wire [WIDTH-1:0]     i_wdata,
    input  wire [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/srs_div.sv
// ---------------------------------------------------------------------------
// srs_div
// Restoring divider, one quotient bit per cycle, for the time increment.
// ---------------------------------------------------------------------------
`default_nettype none

module srs_div import srs_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [DIVIDEND_W-1:0]    i_dividend,
    input  wire [PROP_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [DIVIDEND_W-1:0]   o_quot
);
    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [PROP_W-1:0]     r_rem;
    logic [DIVIDEND_W-1:0] r_q;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [PROP_W:0]       trial;
    logic [PROP_W:0]       diff;
    logic                  ge;

    always_comb begin
        trial = {r_rem, r_q[DIVIDEND_W-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= '0;
            r_q    <= i_dividend;
            r_cnt  <= CW'(DIVIDEND_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[PROP_W-1:0] : trial[PROP_W-1:0];
            r_q   <= {r_q[DIVIDEND_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: hw/rtl/stochastic_reaction_step_top.sv
// ---------------------------------------------------------------------------
// stochastic_reaction_step_top
// Gillespie direct-method step engine on one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
// One transaction in, one result out. Table, count and rate writes, restart
// and unknown ops go straight to the output state; a count read passes
// through a read state first. A step walks the reaction table through a small
// sequencer: for each reaction in use a table read, two count reads and up to
// three passes through the shared multiplier; for each species the source
// rates while irradiating; the selection target; then the selection walk while
// the bit-serial divider runs alongside; and then the count updates. Input is
// not ready during a step; a finished result waits in the output register
// without holding up the next transaction.
`default_nettype none

module stochastic_reaction_step_top import srs_pkg::*; #(
    parameter int MAX_REACTIONS = MAX_REACTIONS_DEF,
    parameter int MAX_SPECIES   = MAX_SPECIES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // tdata: slot[5:0] species_a[10:6] species_b[15:11] first_order[16]
    // rate[48:17] product_one[53:49] product_two[58:54] product_three[63:59]
    // count_value[87:64] uniform[119:88] exp_variate[151:120]
    input  wire [IN_W-1:0]      s_axis_tdata,
    // tuser: op[2:0]
    input  wire [2:0]           s_axis_tuser,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: event_index[5:0] time_now[53:6] read_count[77:54] status[79:78]
    output logic [OUT_W-1:0]    m_axis_tdata,
    // tuser: event_is_source[0]
    output logic [0:0]          m_axis_tuser,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [2:0]           i_cfg_index,
    input  wire [TIME_W-1:0]    i_cfg_data
);
    localparam int RA_W = (MAX_REACTIONS > 1) ? $clog2(MAX_REACTIONS) : 1;
    localparam int IW   = ($clog2(MAX_REACTIONS + 1) > 7) ? $clog2(MAX_REACTIONS + 1) : 7;
    localparam int SW   = $clog2(MAX_SPECIES);
    localparam int XW   = (SW > 5) ? SW : 5;
    localparam int JW   = SW + 1;
    localparam int PK   = (IW > JW) ? IW : JW;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RDC   = 5'd1;
    localparam logic [4:0] S_PA    = 5'd2;
    localparam logic [4:0] S_PB    = 5'd3;
    localparam logic [4:0] S_PC    = 5'd4;
    localparam logic [4:0] S_PD    = 5'd5;
    localparam logic [4:0] S_M1    = 5'd6;
    localparam logic [4:0] S_M2    = 5'd7;
    localparam logic [4:0] S_M3    = 5'd8;
    localparam logic [4:0] S_M4    = 5'd9;
    localparam logic [4:0] S_ACC   = 5'd10;
    localparam logic [4:0] S_SA    = 5'd11;
    localparam logic [4:0] S_SB    = 5'd12;
    localparam logic [4:0] S_TOT   = 5'd13;
    localparam logic [4:0] S_T1    = 5'd14;
    localparam logic [4:0] S_T2    = 5'd15;
    localparam logic [4:0] S_T3    = 5'd16;
    localparam logic [4:0] S_SELA  = 5'd17;
    localparam logic [4:0] S_SELB  = 5'd18;
    localparam logic [4:0] S_SSA   = 5'd19;
    localparam logic [4:0] S_SSB   = 5'd20;
    localparam logic [4:0] S_DIVW  = 5'd21;
    localparam logic [4:0] S_UE    = 5'd22;
    localparam logic [4:0] S_UL    = 5'd23;
    localparam logic [4:0] S_UR    = 5'd24;
    localparam logic [4:0] S_UW    = 5'd25;
    localparam logic [4:0] S_OUT   = 5'd26;

    function automatic logic [SW-1:0] sp_idx(input logic [4:0] s);
        logic [XW-1:0] x;
        x = XW'(s);
        return x[SW-1:0];
    endfunction

    // Input fields
    logic [5:0]            f_slot;
    logic [4:0]            f_sa, f_sb, f_p1, f_p2, f_p3;
    logic                  f_first;
    logic [RATE_W-1:0]     f_rate, f_uniform, f_exp;
    logic [23:0]           f_count;
    logic [2:0]            f_op;

    assign f_slot    = s_axis_tdata[5:0];
    assign f_sa      = s_axis_tdata[10:6];
    assign f_sb      = s_axis_tdata[15:11];
    assign f_first   = s_axis_tdata[16];
    assign f_rate    = s_axis_tdata[48:17];
    assign f_p1      = s_axis_tdata[53:49];
    assign f_p2      = s_axis_tdata[58:54];
    assign f_p3      = s_axis_tdata[63:59];
    assign f_count   = s_axis_tdata[87:64];
    assign f_uniform = s_axis_tdata[119:88];
    assign f_exp     = s_axis_tdata[151:120];
    assign f_op      = s_axis_tuser;

    // Registers
    logic [4:0]            r_state;
    logic [TIME_W-1:0]     r_start_time, r_end_time, r_irr_end, r_time;
    logic [6:0]            r_rcount;
    logic [4:0]            r_none;
    logic [RATE_W-1:0]     r_u, r_exp;
    logic [IW-1:0]         r_n, r_i;
    logic [JW-1:0]         r_j;
    logic                  r_with_src;
    logic [PROP_W-1:0]     r_total, r_part, r_target, r_x, r_plo, r_phi, r_prop;
    logic [RATE_W-1:0]     r_y;
    t_rxn                  r_ent;
    logic [COUNT_BITS-1:0] r_ca, r_cb;
    logic                  r_found, r_src;
    logic [PK-1:0]         r_pick;
    logic [2:0]            r_uidx;
    logic                  r_sa_ok;
    logic [5:0]            r_res_ev;
    logic                  r_res_src;
    logic [23:0]           r_res_rd;
    logic [1:0]            r_res_st;
    logic [MAX_SPECIES-1:0] r_cnt_vld, r_src_vld;
    logic                  r_cnt_vr, r_src_vr;
    logic                  r_m_valid;
    logic [OUT_W-1:0]      r_m_data;
    logic                  r_m_user;

    // Memory ports
    logic                  tbl_we;
    logic [RA_W-1:0]       tbl_waddr, tbl_raddr;
    t_rxn                  tbl_wdata, tbl_rdata;
    logic                  cnt_we;
    logic [SW-1:0]         cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata, cnt_val;
    logic                  src_we;
    logic [SW-1:0]         src_waddr, src_raddr;
    logic [RATE_W-1:0]     src_rdata;
    logic [PROP_W-1:0]     src_val;
    logic                  cache_we;
    logic [RA_W-1:0]       cache_addr;
    logic [PROP_W-1:0]     cache_rdata;

    logic                  in_acc;
    logic [IW-1:0]         n_eff;
    logic [RATE_W-1:0]     mul_a, mul_b;
    logic [PROP_W-1:0]     mul_p;
    logic [95:0]           wsum;
    logic [PROP_W-1:0]     psum_c, psum_s;
    logic [TIME_W:0]       tsum;
    logic                  same_sp, ok_a, ok_b;
    logic [XW-1:0]         upd_sp;
    logic                  upd_inc, upd_skip, upd_last;
    logic                  div_start, div_done;
    logic [DIVIDEND_W-1:0] div_q;
    logic                  out_free;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign same_sp  = (r_ent.a == r_ent.b);
    assign ok_a     = (32'(r_ent.a) < 32'(MAX_SPECIES));
    assign ok_b     = (32'(r_ent.b) < 32'(MAX_SPECIES));
    assign cnt_val  = r_cnt_vr ? cnt_rdata : '0;
    assign src_val  = r_src_vr ? PROP_W'(src_rdata) : '0;
    assign psum_c   = sat_add64(r_part, cache_rdata);
    assign psum_s   = sat_add64(r_part, src_val);
    assign wsum     = {r_phi, 32'b0} + {32'b0, r_plo};
    assign tsum     = {1'b0, r_time} + {1'b0, div_q};
    assign n_eff    = (IW'(r_rcount) > IW'(MAX_REACTIONS)) ? IW'(MAX_REACTIONS)
                                                         : IW'(r_rcount);
    assign div_start = (r_state == S_T3);

    // Shared multiplier
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M1: begin
                if (!r_ent.first && same_sp) begin
                    mul_a = 32'(r_ca);
                    mul_b = 32'(r_ca - 1'b1);
                end else begin
                    mul_a = r_ent.k;
                    mul_b = 32'(r_ca);
                end
            end
            S_M2: begin
                mul_a = r_x[31:0];
                mul_b = r_y;
            end
            S_M3: begin
                mul_a = r_x[63:32];
                mul_b = r_y;
            end
            S_T1: begin
                mul_a = r_u;
                mul_b = r_total[31:0];
            end
            S_T2: begin
                mul_a = r_u;
                mul_b = r_total[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Species touched by the current update slot: products, then A, then B; for a source event the picked species
    always_comb begin
        upd_sp   = '0;
        upd_inc  = 1'b1;
        upd_skip = 1'b0;
        upd_last = 1'b0;
        if (r_src) begin
            upd_sp   = r_pick[XW-1:0];
            upd_skip = (upd_sp == XW'(r_none));
            upd_last = 1'b1;
        end else if (r_uidx < 3'(MAX_PRODUCTS)) begin
            case (r_uidx)
                3'd0:    upd_sp = XW'(r_ent.p1);
                3'd1:    upd_sp = XW'(r_ent.p2);
                default: upd_sp = XW'(r_ent.p3);
            endcase
            upd_skip = (upd_sp == XW'(r_none));
        end else if (r_uidx == 3'(MAX_PRODUCTS)) begin
            upd_sp  = XW'(r_ent.a);
            upd_inc = 1'b0;
        end else begin
            upd_sp   = XW'(r_ent.b);
            upd_inc  = 1'b0;
            upd_skip = r_ent.first;
            upd_last = 1'b1;
        end
        if (!(32'(upd_sp) < 32'(MAX_SPECIES))) begin
            upd_skip = 1'b1;
        end
    end

    // Memory addressing and writes
    always_comb begin
        tbl_we          = in_acc && (f_op == OP_WR_RXN)
                          && (32'(f_slot) < 32'(MAX_REACTIONS));
        tbl_waddr       = RA_W'(f_slot);
        tbl_wdata.a     = f_sa;
        tbl_wdata.b     = f_sb;
        tbl_wdata.first = f_first;
        tbl_wdata.k     = f_rate;
        tbl_wdata.p1    = f_p1;
        tbl_wdata.p2    = f_p2;
        tbl_wdata.p3    = f_p3;
        tbl_raddr       = (r_state == S_UE) ? r_pick[RA_W-1:0] : r_i[RA_W-1:0];

        cnt_we    = 1'b0;
        cnt_waddr = sp_idx(f_sa);
        cnt_wdata = COUNT_BITS'(f_count);
        if (in_acc && (f_op == OP_WR_COUNT) && (32'(f_sa) < 32'(MAX_SPECIES))) begin
            cnt_we = 1'b1;
        end else if (r_state == S_UW) begin
            cnt_we    = 1'b1;
            cnt_waddr = upd_sp[SW-1:0];
            if (upd_inc) begin
                cnt_wdata = (&cnt_val) ? cnt_val : cnt_val + 1'b1;
            end else begin
                cnt_wdata = (cnt_val == '0) ? cnt_val : cnt_val - 1'b1;
            end
        end
        case (r_state)
            S_PB:    cnt_raddr = sp_idx(tbl_rdata.a);
            S_PC:    cnt_raddr = sp_idx(r_ent.b);
            S_UR:    cnt_raddr = upd_sp[SW-1:0];
            default: cnt_raddr = sp_idx(f_sa);
        endcase

        src_we    = in_acc && (f_op == OP_WR_SRC) && (32'(f_sa) < 32'(MAX_SPECIES));
        src_waddr = sp_idx(f_sa);
        src_raddr = r_j[SW-1:0];

        cache_we   = (r_state == S_ACC);
        cache_addr = r_i[RA_W-1:0];
    end

    srs_ram #(.WIDTH($bits(t_rxn)), .DEPTH(MAX_REACTIONS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    srs_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_SPECIES)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    srs_ram #(.WIDTH(RATE_W), .DEPTH(MAX_SPECIES)) u_src (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (src_waddr),
        .i_wdata (f_rate),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    srs_ram #(.WIDTH(PROP_W), .DEPTH(MAX_REACTIONS)) u_cache (
        .i_clk   (i_clk),
        .i_we    (cache_we),
        .i_waddr (cache_addr),
        .i_wdata (r_prop),
        .i_raddr (cache_addr),
        .o_rdata (cache_rdata)
    );

    srs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_exp, 16'b0}),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Valid bits: unwritten counts and rates read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_src_vld <= '0;
            r_cnt_vr  <= 1'b0;
            r_src_vr  <= 1'b0;
        end else begin
            if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end
            if (src_we) begin
                r_src_vld[src_waddr] <= 1'b1;
            end
            r_cnt_vr <= r_cnt_vld[cnt_raddr];
            r_src_vr <= r_src_vld[src_raddr];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= '0;
            r_end_time   <= '1;
            r_irr_end    <= '0;
            r_rcount     <= '0;
            r_none       <= 5'd31;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_TIME: r_start_time <= i_cfg_data;
                CFG_END_TIME:   r_end_time   <= i_cfg_data;
                CFG_IRR_END:    r_irr_end    <= i_cfg_data;
                CFG_RXN_COUNT:  r_rcount     <= i_cfg_data[6:0];
                CFG_NONE_SP:    r_none       <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_time  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_ev  <= '0;
                        r_res_src <= 1'b0;
                        r_res_rd  <= '0;
                        r_res_st  <= ST_OK;
                        r_sa_ok   <= (32'(f_sa) < 32'(MAX_SPECIES));
                        r_state   <= S_OUT;
                        case (f_op)
                            OP_RD_COUNT: r_state <= S_RDC;
                            OP_RESTART:  r_time  <= r_start_time;
                            OP_STEP: begin
                                if (r_time > r_end_time) begin
                                    r_res_st <= ST_PAST;
                                end else begin
                                    r_n        <= n_eff;
                                    r_i        <= '0;
                                    r_j        <= '0;
                                    r_total    <= '0;
                                    r_part     <= '0;
                                    r_found    <= 1'b0;
                                    r_src      <= 1'b0;
                                    r_with_src <= (r_time < r_irr_end);
                                    r_u        <= f_uniform;
                                    r_exp      <= f_exp;
                                    if (n_eff != '0) begin
                                        r_state <= S_PA;
                                    end else if (r_time < r_irr_end) begin
                                        r_state <= S_SA;
                                    end else begin
                                        r_state <= S_TOT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDC: begin
                    r_res_rd <= r_sa_ok ? 24'(cnt_val) : '0;
                    r_state  <= S_OUT;
                end
                S_PA: r_state <= S_PB;
                S_PB: begin
                    r_ent   <= tbl_rdata;
                    r_state <= S_PC;
                end
                S_PC: begin
                    r_ca    <= ok_a ? cnt_val : '0;
                    r_state <= S_PD;
                end
                S_PD: begin
                    r_cb    <= ok_b ? cnt_val : '0;
                    r_state <= S_M1;
                end
                S_M1: begin
                    if (r_ent.first) begin
                        r_prop  <= (r_ca == '0) ? '0 : mul_p;
                        r_state <= S_ACC;
                    end else if (same_sp) begin
                        if (r_ca < COUNT_BITS'(2)) begin
                            r_prop  <= '0;
                            r_state <= S_ACC;
                        end else begin
                            r_x     <= {1'b0, mul_p[PROP_W-1:1]};
                            r_y     <= r_ent.k;
                            r_state <= S_M2;
                        end
                    end else if (r_ca == '0 || r_cb == '0) begin
                        r_prop  <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_x     <= mul_p;
                        r_y     <= 32'(r_cb);
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    r_plo   <= mul_p;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_phi   <= mul_p;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_prop  <= (|wsum[95:64]) ? '1 : wsum[63:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_total <= sat_add64(r_total, r_prop);
                    r_i     <= r_i + 1'b1;
                    if ((r_i + 1'b1) == r_n) begin
                        r_state <= r_with_src ? S_SA : S_TOT;
                    end else begin
                        r_state <= S_PA;
                    end
                end
                S_SA: r_state <= S_SB;
                S_SB: begin
                    r_total <= sat_add64(r_total, src_val);
                    r_j     <= r_j + 1'b1;
                    r_state <= ((r_j + 1'b1) == JW'(MAX_SPECIES)) ? S_TOT : S_SA;
                end
                S_TOT: begin
                    if (r_total == '0) begin
                        r_res_st <= ST_ZERO;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    r_plo   <= mul_p;
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_phi   <= mul_p;
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_target <= r_phi + {32'b0, r_plo[63:32]};
                    r_i      <= '0;
                    r_j      <= '0;
                    if (r_n != '0) begin
                        r_state <= S_SELA;
                    end else begin
                        r_state <= r_with_src ? S_SSA : S_DIVW;
                    end
                end
                S_SELA: r_state <= S_SELB;
                S_SELB: begin
                    r_part <= psum_c;
                    if (r_target < psum_c) begin
                        r_found <= 1'b1;
                        r_pick  <= PK'(r_i);
                        r_state <= S_DIVW;
                    end else if ((r_i + 1'b1) == r_n) begin
                        r_state <= r_with_src ? S_SSA : S_DIVW;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SELA;
                    end
                end
                S_SSA: r_state <= S_SSB;
                S_SSB: begin
                    r_part <= psum_s;
                    if (r_target < psum_s) begin
                        r_found <= 1'b1;
                        r_src   <= 1'b1;
                        r_pick  <= PK'(r_j);
                        r_state <= S_DIVW;
                    end else if ((r_j + 1'b1) == JW'(MAX_SPECIES)) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SSA;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_time <= tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
                        r_uidx <= '0;
                        if (r_found) begin
                            r_res_ev  <= r_pick[5:0];
                            r_res_src <= r_src;
                            r_state   <= r_src ? S_UR : S_UE;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_UE: r_state <= S_UL;
                S_UL: begin
                    r_ent   <= tbl_rdata;
                    r_uidx  <= '0;
                    r_state <= S_UR;
                end
                S_UR: begin
                    if (upd_skip) begin
                        r_uidx  <= r_uidx + 1'b1;
                        r_state <= upd_last ? S_OUT : S_UR;
                    end else begin
                        r_state <= S_UW;
                    end
                end
                S_UW: begin
                    r_uidx  <= r_uidx + 1'b1;
                    r_state <= upd_last ? S_OUT : S_UR;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_m_valid <= 1'b1;
            r_m_data  <= {r_res_st, r_res_rd, r_time, r_res_ev};
            r_m_user  <= r_res_src;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_user;
    assign o_cfg_ready     = 1'b1;

endmodule

`default_nettype wire

// File: hw/rtl/srs_checker.sv
// ---------------------------------------------------------------------------
// srs_checker
// Port-level checks on the step engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module srs_checker import srs_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              s_axis_tvalid,
    input wire              s_axis_tready,
    input wire [OUT_W-1:0]  m_axis_tdata,
    input wire [0:0]        m_axis_tuser,
    input wire              m_axis_tvalid,
    input wire              m_axis_tready
);
    // Held result must not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Busy after every accepted transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[79:78] == ST_OK ||
                           m_axis_tdata[79:78] == ST_ZERO ||
                           m_axis_tdata[79:78] == ST_PAST))
        else $error("bad status code");

    // A refused step reports no event and no count
    a_noevt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[79:78] != ST_OK |->
            m_axis_tdata[5:0] == 6'd0 && m_axis_tuser == 1'b0
            && m_axis_tdata[77:54] == 24'd0)
        else $error("event fields set on a refused step");

endmodule

bind stochastic_reaction_step_top srs_checker u_srs_checker (.*);

`default_nettype wire
